@@ design/pcbc_pkg.sv @@
package pcbc_pkg;

  localparam int MAP_BITS  = 100;
  localparam int HIGH_BITS = MAP_BITS - 64;
  localparam int PAD_BITS  = MAP_BITS + 3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_EXT_CP = 2'd1;
  localparam logic [1:0] REG_TDD    = 2'd2;
  localparam logic [1:0] REG_SP     = 2'd3;

  localparam logic [1:0] DIV_NONE = 2'd0;
  localparam logic [1:0] DIV_3    = 2'd1;
  localparam logic [1:0] DIV_6    = 2'd2;

  localparam logic [3:0] SF_ZERO = 4'd0;
  localparam logic [3:0] SF_FIVE = 4'd5;
  localparam logic [3:0] SF_SIX  = 4'd6;

  localparam logic [5:0] COEF_TDD_MP = 6'd14;
  localparam logic [5:0] COEF_TDD_SP = 6'd29;
  localparam logic [5:0] COEF_FDD_MP = 6'd17;
  localparam logic [5:0] COEF_FDD_SP = 6'd35;

  localparam logic [3:0] SYM_NORMAL   = 4'd11;
  localparam logic [3:0] SYM_EXTENDED = 4'd9;
  localparam logic [7:0] PILOT_MP     = 8'd24;
  localparam logic [7:0] PILOT_SP     = 8'd30;
  localparam logic [6:0] MBSFN_RE     = 7'd102;

  localparam logic [16:0] RECIP_3 = 17'd43691;

  localparam logic signed [20:0] OUT_MAX = 21'sd524287;
  localparam logic signed [20:0] OUT_MIN = -21'sd524288;

  typedef struct packed {
    logic [6:0] width;
    logic       ext_cp;
    logic       tdd;
    logic       single_port;
  } cfg_t;

  typedef struct packed {
    logic       mbsfn;
    logic [9:0] nrbq;
    logic [7:0] k;
    logic [2:0] q;
    logic [2:0] lay;
    logic [3:0] units;
    logic [5:0] coef;
    logic [1:0] div;
    logic [9:0] wq;
  } s1_t;

  typedef struct packed {
    logic        mbsfn;
    logic [17:0] base;
    logic [14:0] ded;
    logic [2:0]  lay;
    logic [16:0] mb;
  } s4_t;

endpackage

@@ design/pcbc_regs.sv @@
module pcbc_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output pcbc_pkg::cfg_t      cfg
);
  import pcbc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_WIDTH:  cfg_nxt.width       = pwdata[6:0];
        REG_EXT_CP: cfg_nxt.ext_cp      = pwdata[0];
        REG_TDD:    cfg_nxt.tdd         = pwdata[0];
        REG_SP:     cfg_nxt.single_port = pwdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {25'd0, cfg_r.width};
      REG_EXT_CP: prdata = {31'd0, cfg_r.ext_cp};
      REG_TDD:    prdata = {31'd0, cfg_r.tdd};
      REG_SP:     prdata = {31'd0, cfg_r.single_port};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width       <= 7'd25;
      cfg_r.ext_cp      <= 1'b0;
      cfg_r.tdd         <= 1'b0;
      cfg_r.single_port <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  a_width_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && paddr[3:2] == REG_WIDTH) |=> cfg_r.width == $past(pwdata[6:0]))
    else $error("cell width register not written");

endmodule

@@ design/pcbc_front.sv @@
module pcbc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcbc_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  input  logic [6:0]                   alloc_rbs,
  input  logic [63:0]                  alloc_map_low,
  input  logic [pcbc_pkg::HIGH_BITS-1:0] alloc_map_high,
  input  logic [2:0]                   bits_per_symbol,
  input  logic [2:0]                   layer_count,
  input  logic [2:0]                   control_symbols,
  input  logic [3:0]                   subframe_index,
  input  logic                         mbsfn_subframe,
  output logic                         s1_valid,
  output pcbc_pkg::s1_t                s1
);
  import pcbc_pkg::*;

  logic [PAD_BITS-1:0] padded;
  logic [6:0]          win;
  logic [5:0]          half;
  logic [2:0]          sum5;
  logic [3:0]          sym_left;
  s1_t                 s1_nxt;
  s1_t                 s1_r;
  logic                s1_v_r;

  assign padded = {alloc_map_high, alloc_map_low, 3'b000};
  assign half   = cfg.width[6:1];

  always_comb begin
    for (int j = 0; j < 7; j++) begin
      win[j] = padded[7'({1'b0, half}) + 7'(j)];
    end
  end

  assign sum5 = 3'(win[1]) + 3'(win[2]) + 3'(win[3]) + 3'(win[4]) + 3'(win[5]);

  assign sym_left = (cfg.ext_cp ? SYM_EXTENDED : SYM_NORMAL) - {1'b0, control_symbols};

  always_comb begin
    s1_nxt.mbsfn = mbsfn_subframe;
    s1_nxt.q     = bits_per_symbol;
    s1_nxt.nrbq  = 10'(alloc_rbs * bits_per_symbol);
    s1_nxt.wq    = 10'(cfg.width * bits_per_symbol);
    s1_nxt.k     = {sym_left, 3'b000} + {1'b0, sym_left, 2'b00}
                 + (cfg.single_port ? PILOT_SP : PILOT_MP);
    s1_nxt.lay   = cfg.single_port ? 3'd1 : layer_count;
    if (cfg.width[0]) begin
      s1_nxt.units = 4'(win[0]) + 4'(win[6]) + {sum5, 1'b0};
    end else begin
      s1_nxt.units = {3'(win[0]) + sum5, 1'b0};
    end
    unique case (subframe_index)
      SF_ZERO: begin
        if (cfg.tdd) begin
          s1_nxt.coef = cfg.single_port ? COEF_TDD_SP : COEF_TDD_MP;
        end else begin
          s1_nxt.coef = cfg.single_port ? COEF_FDD_SP : COEF_FDD_MP;
        end
        s1_nxt.coef = s1_nxt.coef - {5'd0, cfg.ext_cp};
        s1_nxt.div  = cfg.single_port ? DIV_6 : DIV_3;
      end
      SF_FIVE: begin
        s1_nxt.coef = cfg.tdd ? 6'd1 : 6'd2;
        s1_nxt.div  = DIV_NONE;
      end
      SF_SIX: begin
        s1_nxt.coef = cfg.tdd ? 6'd1 : 6'd0;
        s1_nxt.div  = DIV_NONE;
      end
      default: begin
        s1_nxt.coef = 6'd0;
        s1_nxt.div  = DIV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_v_r;
  assign s1       = s1_r;

endmodule

@@ design/pcbc_core.sv @@
module pcbc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  input  pcbc_pkg::s1_t s1,
  output logic          s4_valid,
  output pcbc_pkg::s4_t s4
);
  import pcbc_pkg::*;

  typedef struct packed {
    logic        mbsfn;
    logic [17:0] base;
    logic [8:0]  req;
    logic [5:0]  coef;
    logic [1:0]  div;
    logic [2:0]  lay;
    logic [16:0] mb;
  } s2_t;

  typedef struct packed {
    logic        mbsfn;
    logic [17:0] base;
    logic [14:0] raw;
    logic [1:0]  div;
    logic [2:0]  lay;
    logic [16:0] mb;
  } s3_t;

  s2_t   s2_r, s2_nxt;
  s3_t   s3_r, s3_nxt;
  s4_t   s4_r, s4_nxt;
  logic  s2_v_r, s3_v_r, s4_v_r;
  logic [14:0] dividend;
  logic [31:0] recip_prod;
  logic [6:0]  uq;

  assign uq = 7'(s1.units * s1.q);

  always_comb begin
    s2_nxt.mbsfn = s1.mbsfn;
    s2_nxt.base  = 18'(s1.nrbq * s1.k);
    s2_nxt.req   = {uq, 2'b00} + {1'b0, uq, 1'b0};
    s2_nxt.coef  = s1.coef;
    s2_nxt.div   = s1.div;
    s2_nxt.lay   = s1.lay;
    s2_nxt.mb    = 17'(s1.wq * MBSFN_RE);
  end

  always_comb begin
    s3_nxt.mbsfn = s2_r.mbsfn;
    s3_nxt.base  = s2_r.base;
    s3_nxt.raw   = 15'(s2_r.coef * s2_r.req);
    s3_nxt.div   = s2_r.div;
    s3_nxt.lay   = s2_r.lay;
    s3_nxt.mb    = s2_r.mb;
  end

  assign dividend   = (s3_r.div == DIV_6) ? {1'b0, s3_r.raw[14:1]} : s3_r.raw;
  assign recip_prod = dividend * RECIP_3;

  always_comb begin
    s4_nxt.mbsfn = s3_r.mbsfn;
    s4_nxt.base  = s3_r.base;
    s4_nxt.ded   = (s3_r.div == DIV_NONE) ? s3_r.raw : recip_prod[31:17];
    s4_nxt.lay   = s3_r.lay;
    s4_nxt.mb    = s3_r.mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_valid;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
  end

  assign s4_valid = s4_v_r;
  assign s4       = s4_r;

  a_div3: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_r.div == DIV_3) |=>
      (32'(s4_r.ded) * 3 <= 32'($past(s3_r.raw))) &&
      (32'($past(s3_r.raw)) - 32'(s4_r.ded) * 3 < 3))
    else $error("divide by three off");

endmodule

@@ design/pcbc_tail.sv @@
module pcbc_tail (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s4_valid,
  input  pcbc_pkg::s4_t       s4,
  output logic                out_valid,
  output logic signed [19:0]  out_coded_bits
);
  import pcbc_pkg::*;

  logic signed [18:0] diff_r, diff_nxt;
  logic [2:0]         lay5_r;
  logic               mbsfn5_r;
  logic [16:0]        mb5_r;
  logic signed [20:0] g_r, g_nxt;
  logic signed [22:0] scaled;
  logic signed [19:0] out_r, out_nxt;
  logic               v5_r, v6_r, v7_r;

  assign diff_nxt = $signed({1'b0, s4.base}) - $signed({4'd0, s4.ded});
  assign scaled   = diff_r * $signed({1'b0, lay5_r});
  assign g_nxt    = mbsfn5_r ? $signed({4'd0, mb5_r}) : scaled[20:0];

  always_comb begin
    if (g_r > OUT_MAX) begin
      out_nxt = OUT_MAX[19:0];
    end else if (g_r < OUT_MIN) begin
      out_nxt = OUT_MIN[19:0];
    end else begin
      out_nxt = g_r[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v5_r <= s4_valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r   <= diff_nxt;
    lay5_r   <= s4.lay;
    mbsfn5_r <= s4.mbsfn;
    mb5_r    <= s4.mb;
    g_r      <= g_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid      = v7_r;
  assign out_coded_bits = out_r;

endmodule

@@ design/pdsch_coded_bit_count_top.sv @@
// coded bit count for one downlink allocation, seven register stages
// a request's valid bit runs through s1, s2, s3, s4, v5, v6 and v7 to the result strobe
// throughput: one request per cycle, busy stays low, the fixed pipeline sets it
// results cannot be stalled; each is on out_ for exactly one cycle
// synchronous active-low reset clears valid bits and loads register defaults
module pdsch_coded_bit_count_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [6:0]                     in_alloc_rbs,
  input  logic [63:0]                    in_alloc_map_low,
  input  logic [pcbc_pkg::HIGH_BITS-1:0] in_alloc_map_high,
  input  logic [2:0]                     in_bits_per_symbol,
  input  logic [2:0]                     in_layer_count,
  input  logic [2:0]                     in_control_symbols,
  input  logic [3:0]                     in_subframe_index,
  input  logic                           in_mbsfn_subframe,
  output logic                           out_valid,
  output logic signed [19:0]             out_coded_bits,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pcbc_pkg::*;

  cfg_t cfg;
  s1_t  s1;
  s4_t  s4;
  logic s1_valid;
  logic s4_valid;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pcbc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcbc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (accept),
    .alloc_rbs       (in_alloc_rbs),
    .alloc_map_low   (in_alloc_map_low),
    .alloc_map_high  (in_alloc_map_high),
    .bits_per_symbol (in_bits_per_symbol),
    .layer_count     (in_layer_count),
    .control_symbols (in_control_symbols),
    .subframe_index  (in_subframe_index),
    .mbsfn_subframe  (in_mbsfn_subframe),
    .s1_valid        (s1_valid),
    .s1              (s1)
  );

  pcbc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s4_valid (s4_valid),
    .s4       (s4)
  );

  pcbc_tail u_tail (
    .clk            (clk),
    .rst_n          (rst_n),
    .s4_valid       (s4_valid),
    .s4             (s4),
    .out_valid      (out_valid),
    .out_coded_bits (out_coded_bits)
  );

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("request without result");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 7))
    else $error("result without request");

endmodule
